/* hdl/tfmf_pkg.sv */
// Shared types and codes of the timed flow mixing FIFO.
package tfmf_pkg;

  localparam int ValW   = 32;
  localparam int TickW  = 16;
  localparam int OutTW  = 20;
  localparam int DivNW  = 64;
  localparam int DivDW  = 33;
  localparam int DivCntW = $clog2(DivNW);

  typedef enum logic [1:0] {
    MODE_PUT   = 2'd0,
    MODE_TAKE  = 2'd1,
    MODE_CLEAR = 2'd2,
    MODE_NOP   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_SHORT = 2'd2,
    ST_ZERO  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_MUL,
    S_SGO,
    S_SDIV,
    S_MIX,
    S_MIXW,
    S_NEXT
  } state_t;

  typedef struct packed {
    logic [1:0]      mode;
    logic [TickW-1:0] duration;
    logic [ValW-1:0] quantity;
    logic [ValW-1:0] conc_a;
    logic [ValW-1:0] conc_b;
    logic [ValW-1:0] conc_c;
    logic [ValW-1:0] conc_d;
  } in_beat_t;

  typedef struct packed {
    logic [ValW-1:0]  taken_quantity;
    logic [ValW-1:0]  mix_a;
    logic [ValW-1:0]  mix_b;
    logic [ValW-1:0]  mix_c;
    logic [ValW-1:0]  mix_d;
    logic [OutTW-1:0] stored_time;
    logic [1:0]       status;
  } out_beat_t;

endpackage

/* hdl/tfmf_div.sv */
// Restoring divider, one quotient bit per cycle.
module tfmf_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [tfmf_pkg::DivNW-1:0]  dividend,
  input  logic [tfmf_pkg::DivDW-1:0]  divisor,
  output logic                        done,
  output logic [tfmf_pkg::ValW-1:0]   quot
);
  import tfmf_pkg::*;

  logic                run_r;
  logic                done_r;
  logic [DivCntW-1:0]  cnt_r;
  logic [DivDW:0]      rem_r;
  logic [DivNW-1:0]    quo_r;
  logic [DivDW-1:0]    dvs_r;
  logic [DivDW:0]      rem_sh;
  logic                qbit;
  logic [DivDW:0]      rem_nxt;

  always_comb begin
    rem_sh  = {rem_r[DivDW-1:0], quo_r[DivNW-1]};
    qbit    = (rem_sh >= {1'b0, dvs_r});
    rem_nxt = qbit ? (rem_sh - {1'b0, dvs_r}) : rem_sh;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DivCntW'(DivNW - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (run_r) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[DivNW-2:0], qbit};
    end
  end

  assign done = done_r;
  assign quot = quo_r[ValW-1:0];

endmodule

/* hdl/tfmf_lane.sv */
// One concentration lane: weighted mix step through multiply and divide.
module tfmf_lane (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [tfmf_pkg::ValW-1:0]  mix_in,
  input  logic [tfmf_pkg::ValW-1:0]  conc,
  input  logic [tfmf_pkg::ValW-1:0]  prev_qty,
  input  logic [tfmf_pkg::ValW-1:0]  share,
  output logic                       done,
  output logic [tfmf_pkg::ValW-1:0]  mix_out
);
  import tfmf_pkg::*;

  logic                st1_r;
  logic                st2_r;
  logic                up_r;
  logic [ValW-1:0]     m_r;
  logic [ValW-1:0]     diff_r;
  logic [ValW-1:0]     w_r;
  logic [DivDW-1:0]    d_r;
  logic [DivNW-1:0]    prod_r;
  logic [DivNW-1:0]    mul_w;
  logic [DivNW-1:0]    dividend;
  logic [ValW-1:0]     q;

  assign mul_w = diff_r * w_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st1_r <= 1'b0;
      st2_r <= 1'b0;
    end else begin
      st1_r <= start;
      st2_r <= st1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      m_r    <= mix_in;
      up_r   <= (conc >= mix_in);
      diff_r <= (conc >= mix_in) ? (conc - mix_in) : (mix_in - conc);
      w_r    <= share;
      d_r    <= {1'b0, prev_qty} + {1'b0, share};
    end
    if (st1_r) prod_r <= mul_w;
  end

  // rounding toward the lower value when the mix falls
  assign dividend = up_r ? prod_r
                         : (prod_r + {{(DivNW-DivDW){1'b0}}, d_r} - DivNW'(1));

  tfmf_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (st2_r),
    .dividend (dividend),
    .divisor  (d_r),
    .done     (done),
    .quot     (q)
  );

  assign mix_out = up_r ? (m_r + q) : (m_r - q);

endmodule

/* hdl/timed_flow_mixing_fifo.sv */
// Top level: event FIFO, take sequencer, share divider and concentration lanes.
// Put, clear, no-op and a take that drains nothing answer at once: the result
// strobes on the cycle after start and busy never rises. A take keeps busy
// high while it works through each event it touches (event read, share
// multiply, 64-step share division, then the lanes' multiply and 64-step
// division run in parallel); for an event where both the running total and
// the share are zero the mix step is skipped. The result strobes in the
// cycle after the last event. The two serial dividers take most of a take. The
// result beat is shown on out_valid for exactly one cycle and cannot be held
// off, so it must be captured when it appears. Stored events are not cleared
// at reset; only the pointers, count, time total, state and strobe are.
module timed_flow_mixing_fifo #(
  parameter int FIFO_DEPTH = 16,
  parameter int NUM_CONC   = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  tfmf_pkg::in_beat_t   in_data,
  output logic                 out_valid,
  output tfmf_pkg::out_beat_t  out_data
);
  import tfmf_pkg::*;

  localparam int PtrW   = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CntW   = $clog2(FIFO_DEPTH + 1);
  localparam int TNeedW = $clog2(FIFO_DEPTH * 65535 + 1);
  localparam int TimeW  = (TNeedW > OutTW) ? TNeedW : OutTW;
  localparam int CW     = NUM_CONC * ValW;

  logic [TickW-1:0]  len_mem  [FIFO_DEPTH];
  logic [TickW-1:0]  left_mem [FIFO_DEPTH];
  logic [ValW-1:0]   amt_mem  [FIFO_DEPTH];
  logic [CW-1:0]     conc_mem [FIFO_DEPTH];

  logic [TickW-1:0]  rd_len_r;
  logic [TickW-1:0]  rd_left_r;
  logic [ValW-1:0]   rd_amt_r;
  logic [CW-1:0]     rd_conc_r;

  state_t            state_r, state_nxt;
  logic [PtrW-1:0]   head_r, tail_r;
  logic [CntW-1:0]   count_r;
  logic [TimeW-1:0]  time_r;
  logic              out_valid_r;
  out_beat_t         out_data_r;

  logic [TickW-1:0]  rem_r;
  logic [TickW-1:0]  portion_r;
  logic [ValW-1:0]   taken_r;
  logic [ValW-1:0]   share_r;
  logic [47:0]       prod_r;
  logic [ValW-1:0]   mix_r [NUM_CONC];

  logic              accept;
  logic              take_go;
  logic              put_ok;
  logic [CW-1:0]     put_conc;
  logic [TickW-1:0]  portion;
  logic              sdiv_done;
  logic [ValW-1:0]   sdiv_q;
  logic [NUM_CONC-1:0] lane_done;
  logic [ValW-1:0]   lane_res [NUM_CONC];
  logic [ValW-1:0]   mix_pad [4];
  status_t           acc_status;
  logic [OutTW-1:0]  acc_time;

  logic [ValW:0]     sum_w;
  logic [ValW-1:0]   taken_nxt;
  logic [TickW-1:0]  rem_nxt;
  logic [TimeW-1:0]  time_sub;
  logic              whole;
  logic [CntW-1:0]   count_dec;
  logic              more;

  assign accept = start && (state_r == S_IDLE);
  assign take_go = accept && (mode_t'(in_data.mode) == MODE_TAKE)
                   && (in_data.duration != '0) && (count_r != '0);
  assign put_ok = accept && (mode_t'(in_data.mode) == MODE_PUT)
                  && (in_data.duration != '0) && (count_r != CntW'(FIFO_DEPTH));
  assign portion = (rem_r >= rd_left_r) ? rd_left_r : rem_r;

  always_comb begin
    for (int j = 0; j < NUM_CONC; j++) begin
      case (j)
        0:       put_conc[j*ValW +: ValW] = in_data.conc_a;
        1:       put_conc[j*ValW +: ValW] = in_data.conc_b;
        2:       put_conc[j*ValW +: ValW] = in_data.conc_c;
        3:       put_conc[j*ValW +: ValW] = in_data.conc_d;
        default: put_conc[j*ValW +: ValW] = '0;
      endcase
    end
  end

  always_comb begin
    for (int j = 0; j < 4; j++) mix_pad[j] = '0;
    for (int j = 0; j < NUM_CONC; j++) begin
      if (j < 4) mix_pad[j] = mix_r[j];
    end
  end

  always_comb begin
    acc_status = ST_OK;
    acc_time   = time_r[OutTW-1:0];
    case (mode_t'(in_data.mode))
      MODE_PUT: begin
        if (in_data.duration == '0) acc_status = ST_ZERO;
        else if (count_r == CntW'(FIFO_DEPTH)) acc_status = ST_FULL;
        else acc_time = OutTW'(time_r + TimeW'(in_data.duration));
      end
      MODE_TAKE: if (in_data.duration != '0 && count_r == '0) acc_status = ST_SHORT;
      MODE_CLEAR: acc_time = '0;
      default: ;
    endcase
  end

  always_comb begin
    sum_w     = {1'b0, taken_r} + {1'b0, share_r};
    taken_nxt = sum_w[ValW] ? '1 : sum_w[ValW-1:0];
    rem_nxt   = rem_r - portion_r;
    time_sub  = (time_r >= TimeW'(portion_r)) ? (time_r - TimeW'(portion_r)) : '0;
    whole     = (portion_r == rd_left_r);
    count_dec = whole ? (count_r - 1'b1) : count_r;
    more      = (rem_nxt != '0) && (count_dec != '0);
  end

  // event store
  always_ff @(posedge clk) begin
    if (put_ok) begin
      len_mem[tail_r]  <= in_data.duration;
      left_mem[tail_r] <= in_data.duration;
      amt_mem[tail_r]  <= in_data.quantity;
      conc_mem[tail_r] <= put_conc;
    end else if (state_r == S_NEXT && !whole) begin
      left_mem[head_r] <= rd_left_r - portion_r;
    end
    rd_len_r  <= len_mem[head_r];
    rd_left_r <= left_mem[head_r];
    rd_amt_r  <= amt_mem[head_r];
    rd_conc_r <= conc_mem[head_r];
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (take_go) state_nxt = S_RD;
      S_RD:   state_nxt = S_MUL;
      S_MUL:  state_nxt = S_SGO;
      S_SGO:  state_nxt = S_SDIV;
      S_SDIV: if (sdiv_done) state_nxt = (taken_r != '0 || sdiv_q != '0) ? S_MIX : S_NEXT;
      S_MIX:  state_nxt = S_MIXW;
      S_MIXW: if (&lane_done) state_nxt = S_NEXT;
      S_NEXT: state_nxt = more ? S_RD : S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      time_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (accept && !take_go) || (state_r == S_NEXT && !more);
      if (accept) begin
        if (put_ok) begin
          tail_r  <= (tail_r == PtrW'(FIFO_DEPTH - 1)) ? '0 : tail_r + 1'b1;
          count_r <= count_r + 1'b1;
          time_r  <= time_r + TimeW'(in_data.duration);
        end
        if (mode_t'(in_data.mode) == MODE_CLEAR) begin
          head_r  <= '0;
          tail_r  <= '0;
          count_r <= '0;
          time_r  <= '0;
        end
      end
      if (state_r == S_NEXT) begin
        time_r  <= time_sub;
        count_r <= count_dec;
        if (whole) head_r <= (head_r == PtrW'(FIFO_DEPTH - 1)) ? '0 : head_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rem_r   <= in_data.duration;
      taken_r <= '0;
      for (int j = 0; j < NUM_CONC; j++) mix_r[j] <= '0;
      out_data_r.taken_quantity <= '0;
      out_data_r.mix_a <= '0;
      out_data_r.mix_b <= '0;
      out_data_r.mix_c <= '0;
      out_data_r.mix_d <= '0;
      out_data_r.status <= acc_status;
      out_data_r.stored_time <= acc_time;
    end
    if (state_r == S_MUL) begin
      portion_r <= portion;
      prod_r    <= rd_amt_r * portion;
    end
    if (state_r == S_SDIV && sdiv_done) share_r <= sdiv_q;
    if (state_r == S_MIXW && (&lane_done)) begin
      for (int j = 0; j < NUM_CONC; j++) mix_r[j] <= lane_res[j];
    end
    if (state_r == S_NEXT) begin
      taken_r <= taken_nxt;
      rem_r   <= rem_nxt;
      if (!more) begin
        out_data_r.taken_quantity <= taken_nxt;
        out_data_r.mix_a <= mix_pad[0];
        out_data_r.mix_b <= mix_pad[1];
        out_data_r.mix_c <= mix_pad[2];
        out_data_r.mix_d <= mix_pad[3];
        out_data_r.stored_time <= time_sub[OutTW-1:0];
        out_data_r.status <= (rem_nxt != '0) ? ST_SHORT : ST_OK;
      end
    end
  end

  tfmf_div u_share_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (state_r == S_SGO),
    .dividend ({16'b0, prod_r}),
    .divisor  ({17'b0, rd_len_r}),
    .done     (sdiv_done),
    .quot     (sdiv_q)
  );

  for (genvar g = 0; g < NUM_CONC; g++) begin : g_lane
    tfmf_lane u_lane (
      .clk      (clk),
      .rst_n    (rst_n),
      .start    (state_r == S_MIX),
      .mix_in   (mix_r[g]),
      .conc     (rd_conc_r[g*ValW +: ValW]),
      .prev_qty (taken_r),
      .share    (share_r),
      .done     (lane_done[g]),
      .mix_out  (lane_res[g])
    );
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_valid_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result while take in progress");

  a_time_count: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) == (time_r == '0)) else $error("time total out of step with count");

  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CntW'(FIFO_DEPTH)) else $error("entry count beyond depth");

  a_take_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_valid)) else $error("accepted beat gave no result");

endmodule

/* dv/testbench.sv */
// Self-checking testbench for the timed flow mixing FIFO: predicted beats vs. DUT.
module testbench;
  import tfmf_pkg::*;

  localparam int Depth = 16;
  localparam int Lanes = 4;
  localparam longint CycleLimit = 20000000;

  class flow_scoreboard;
    logic [15:0] ev_len[Depth];
    logic [15:0] ev_left[Depth];
    logic [31:0] ev_amt[Depth];
    logic [31:0] ev_conc[Depth][Lanes];
    int unsigned head, tail, count, ticks_held;
    out_beat_t expected_q[$];
    int errors;

    function new();
      head = 0;
      tail = 0;
      count = 0;
      ticks_held = 0;
      errors = 0;
    endfunction

    // floor((m*p + c*w) / (p + w))
    function logic [31:0] blend(logic [31:0] m, logic [31:0] c, logic [31:0] p,
                                logic [31:0] w);
      longint unsigned d, delta;
      d = longint'(p) + longint'(w);
      if (c >= m) begin
        delta = {32'b0, c - m};
        delta = (delta * {32'b0, w}) / d;
        return m + delta[31:0];
      end
      delta = {32'b0, m - c};
      delta = (delta * {32'b0, w} + d - 1) / d;
      return m - delta[31:0];
    endfunction

    function void note_input(in_beat_t b);
      out_beat_t e;
      logic [31:0] mix[Lanes];
      logic [31:0] taken, share;
      int unsigned rem, left, len, portion, s;
      longint unsigned sum;
      e = '0;
      taken = 0;
      for (int j = 0; j < Lanes; j++) mix[j] = 0;
      e.status = ST_OK;
      case (b.mode)
        MODE_PUT: begin
          if (b.duration == 0) begin
            e.status = ST_ZERO;
          end else if (count >= Depth) begin
            e.status = ST_FULL;
          end else begin
            ev_len[tail] = b.duration;
            ev_left[tail] = b.duration;
            ev_amt[tail] = b.quantity;
            ev_conc[tail][0] = b.conc_a;
            ev_conc[tail][1] = b.conc_b;
            ev_conc[tail][2] = b.conc_c;
            ev_conc[tail][3] = b.conc_d;
            tail = (tail + 1) % Depth;
            count++;
            ticks_held += b.duration;
          end
        end
        MODE_TAKE: begin
          rem = b.duration;
          while (rem > 0 && count > 0) begin
            s = head;
            left = ev_left[s];
            len = ev_len[s];
            portion = (rem >= left) ? left : rem;
            share = 0;
            if (len != 0) share = (longint'(ev_amt[s]) * portion) / len;
            if (taken != 0 || share != 0)
              for (int j = 0; j < Lanes; j++)
                mix[j] = blend(mix[j], ev_conc[s][j], taken, share);
            sum = longint'(taken) + longint'(share);
            taken = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
            rem -= portion;
            ticks_held = (ticks_held >= portion) ? ticks_held - portion : 0;
            if (portion == left) begin
              head = (s + 1) % Depth;
              count--;
            end else begin
              ev_left[s] = left - portion;
            end
            if (left == 0) begin
              head = (s + 1) % Depth;
              if (portion != left) count--;
            end
          end
          if (rem > 0) e.status = ST_SHORT;
          e.taken_quantity = taken;
          e.mix_a = mix[0];
          e.mix_b = mix[1];
          e.mix_c = mix[2];
          e.mix_d = mix[3];
        end
        MODE_CLEAR: begin
          head = 0;
          tail = 0;
          count = 0;
          ticks_held = 0;
        end
        default: ;
      endcase
      e.stored_time = ticks_held[19:0];
      expected_q.insert(expected_q.size(), e);
    endfunction

    function void check_result(out_beat_t got);
      out_beat_t exp;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result beat %h", $time, got);
        errors++;
        return;
      end
      exp = expected_q[0];
      expected_q.delete(0);
      if (got.taken_quantity !== exp.taken_quantity) begin
        $display("%0t: taken_quantity exp %h got %h", $time, exp.taken_quantity,
                 got.taken_quantity);
        errors++;
      end
      if (got.mix_a !== exp.mix_a) begin
        $display("%0t: mix_a exp %h got %h", $time, exp.mix_a, got.mix_a);
        errors++;
      end
      if (got.mix_b !== exp.mix_b) begin
        $display("%0t: mix_b exp %h got %h", $time, exp.mix_b, got.mix_b);
        errors++;
      end
      if (got.mix_c !== exp.mix_c) begin
        $display("%0t: mix_c exp %h got %h", $time, exp.mix_c, got.mix_c);
        errors++;
      end
      if (got.mix_d !== exp.mix_d) begin
        $display("%0t: mix_d exp %h got %h", $time, exp.mix_d, got.mix_d);
        errors++;
      end
      if (got.stored_time !== exp.stored_time) begin
        $display("%0t: stored_time exp %h got %h", $time, exp.stored_time,
                 got.stored_time);
        errors++;
      end
      if (got.status !== exp.status) begin
        $display("%0t: status exp %h got %h", $time, exp.status, got.status);
        errors++;
      end
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_beat_t  in_data;
  logic      out_valid;
  out_beat_t out_data;

  flow_scoreboard flow_sb;
  longint cycles;

  timed_flow_mixing_fifo #(.FIFO_DEPTH(Depth), .NUM_CONC(Lanes)) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) flow_sb.note_input(in_data);
      if (out_valid) flow_sb.check_result(out_data);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send_beat(in_beat_t b, int idle_pct);
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_data <= b;
    start <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  function automatic in_beat_t mk_beat(mode_t m, logic [15:0] dur, logic [31:0] q);
    in_beat_t b;
    b.mode = m;
    b.duration = dur;
    b.quantity = q;
    b.conc_a = $urandom;
    b.conc_b = $urandom;
    b.conc_c = $urandom;
    b.conc_d = $urandom;
    return b;
  endfunction

  function automatic logic [31:0] rand_quantity();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(0, 32'h0010_0000);
      default: return $urandom;
    endcase
  endfunction

  function automatic in_beat_t rand_beat();
    int unsigned pick;
    logic [15:0] dur;
    pick = $urandom_range(0, 99);
    if (pick < 48) begin
      case ($urandom_range(0, 19))
        0: dur = 0;
        1: dur = $urandom;
        2: dur = 16'hFFFF;
        default: dur = $urandom_range(1, 120);
      endcase
      return mk_beat(MODE_PUT, dur, rand_quantity());
    end
    if (pick < 90) begin
      case ($urandom_range(0, 9))
        0: dur = 0;
        1: dur = $urandom;
        default: dur = $urandom_range(1, 250);
      endcase
      return mk_beat(MODE_TAKE, dur, $urandom);
    end
    if (pick < 95) return mk_beat(MODE_CLEAR, $urandom, $urandom);
    return mk_beat(MODE_NOP, $urandom, $urandom);
  endfunction

  initial begin
    in_beat_t b;
    int idle_pct[3];
    flow_sb = new();
    cycles = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    idle_pct[0] = 25;
    idle_pct[1] = 86;
    idle_pct[2] = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty take, zero take, rejections, extremes, full FIFO, clear
    send_beat(mk_beat(MODE_TAKE, 16'd5, 0), 0);
    send_beat(mk_beat(MODE_TAKE, 16'd0, 0), 0);
    send_beat(mk_beat(MODE_PUT, 16'd0, 32'hFFFF_FFFF), 0);
    send_beat(mk_beat(MODE_NOP, 16'hFFFF, 32'hFFFF_FFFF), 0);
    b = mk_beat(MODE_PUT, 16'hFFFF, 32'hFFFF_FFFF);
    b.conc_a = '1;
    b.conc_b = '0;
    b.conc_c = '1;
    b.conc_d = '0;
    send_beat(b, 0);
    send_beat(mk_beat(MODE_PUT, 16'd1, 32'd0), 0);
    for (int i = 0; i < 15; i++)
      send_beat(mk_beat(MODE_PUT, 16'($urandom_range(1, 40)), rand_quantity()), 0);
    send_beat(mk_beat(MODE_TAKE, 16'd7, 0), 0);
    send_beat(mk_beat(MODE_TAKE, 16'hFFFF, 0), 0);
    send_beat(mk_beat(MODE_TAKE, 16'hFFFF, 0), 0);
    send_beat(mk_beat(MODE_PUT, 16'd3, 32'h0001_0000), 0);
    send_beat(mk_beat(MODE_CLEAR, 16'd0, 0), 0);

    for (int ph = 0; ph < 3; ph++)
      for (int i = 0; i < 330; i++) send_beat(rand_beat(), idle_pct[ph]);
    start <= 1'b0;

    while (flow_sb.expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (flow_sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

/* files.f */
hdl/tfmf_pkg.sv
hdl/tfmf_div.sv
hdl/tfmf_lane.sv
hdl/timed_flow_mixing_fifo.sv
dv/testbench.sv
